// ----- hw/rtl/mfba_pkg.sv -----
// Package with types and constants for the max-flow augmenting-path block.
`default_nettype none
package mfba_pkg;
  localparam int MAX_NODES_DEF = 16;
  localparam int CAP_BITS_DEF = 16;
  localparam logic [19:0] FLOW_MAX = 20'hFFFFF;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  from_node;
    logic [3:0]  to_node;
    logic [15:0] capacity;
    logic [3:0]  source_node;
    logic [3:0]  sink_node;
  } in_word_t;

  typedef struct packed {
    logic [19:0] flow_value;
    logic        error;
  } out_word_t;
endpackage
`default_nettype wire

// ----- hw/rtl/max_flow_bfs_augment.sv -----
// Top level: capacity store and breadth-first augmenting-path max-flow solver.
// A write word stores one capacity. A solve copies the active N x N capacities into the
// residual memory, then each search pops queued nodes and scans a residual row for each.
// Each augmentation finds the path bottleneck, then updates both residuals of each edge.
// One word at a time; a result word is registered in S_DONE and blocks input until taken.
// On synchronous reset S_CLEAR wipes capacity memory, one entry per cycle (256 entries).
`default_nettype none
module max_flow_bfs_augment #(
  parameter int MAX_NODES = mfba_pkg::MAX_NODES_DEF,
  parameter int CAP_BITS = mfba_pkg::CAP_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [4:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mfba_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mfba_pkg::out_word_t      out_data
);
  import mfba_pkg::*;

  localparam int NB = (MAX_NODES > 16) ? $clog2(MAX_NODES) : 4;
  localparam int AB = 2 * NB;
  localparam int DEPTH = 1 << AB;
  localparam int RB = CAP_BITS + 1;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_COPY   = 4'd2;
  localparam logic [3:0] S_BINIT  = 4'd3;
  localparam logic [3:0] S_BPOP   = 4'd4;
  localparam logic [3:0] S_BSCAN  = 4'd5;
  localparam logic [3:0] S_NRD    = 4'd6;
  localparam logic [3:0] S_NWT    = 4'd7;
  localparam logic [3:0] S_ARD    = 4'd8;
  localparam logic [3:0] S_AWR    = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [CAP_BITS-1:0] cap_mem [DEPTH];
  logic [RB-1:0]       res_mem [DEPTH];
  logic [NB-1:0]       parent [MAX_NODES];
  logic [NB-1:0]       queue [MAX_NODES];

  logic [3:0]  state;
  logic [4:0]  node_count;
  logic [NB:0] n;
  logic [AB:0] cnt;
  logic [NB-1:0] src, dst, u, v, w;
  logic [NB:0] head, tail, steps, scan;
  logic        scan_vld;
  logic [MAX_NODES-1:0] visited;
  logic [19:0] total;
  logic [RB-1:0] neck;
  logic [RB-1:0] cap_q, res_q;
  logic          fix_pass;
  logic          err;

  // Memory ports.
  logic          cap_we, res_we;
  logic [AB-1:0] cap_wa, cap_ra, res_wa, res_ra;
  logic [CAP_BITS-1:0] cap_wd;
  logic [RB-1:0] res_wd;

  always_ff @(posedge clk) begin
    if (cap_we) cap_mem[cap_wa] <= cap_wd;
    cap_q <= RB'(cap_mem[cap_ra]);
    if (res_we) res_mem[res_wa] <= res_wd;
    res_q <= res_mem[res_ra];
  end

  logic [NB:0] ncfg;
  assign ncfg = (node_count > 5'(MAX_NODES)) ? (NB+1)'(MAX_NODES) : (NB+1)'(node_count);

  logic [NB-1:0] pv;
  assign pv = parent[v];
  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cap_we = 1'b0;
    cap_wa = '0;
    cap_wd = '0;
    cap_ra = '0;
    res_we = 1'b0;
    res_wa = '0;
    res_wd = '0;
    res_ra = '0;
    unique case (state)
      S_CLEAR: begin
        cap_we = 1'b1;
        cap_wa = cnt[AB-1:0];
      end
      S_IDLE: begin
        cap_we = in_valid && in_ready && (in_data.opcode == OP_WRITE)
                 && (32'(in_data.from_node) < MAX_NODES) && (32'(in_data.to_node) < MAX_NODES);
        cap_wa = {NB'(in_data.from_node), NB'(in_data.to_node)};
        cap_wd = CAP_BITS'(in_data.capacity);
        cap_ra = '0;
      end
      S_COPY: begin
        cap_ra = cnt[AB-1:0];
        res_we = scan_vld;
        res_wa = {u, w};
        res_wd = cap_q;
      end
      S_BSCAN: res_ra = {u, scan[NB-1:0]};
      S_NRD:   res_ra = {pv, v};
      S_ARD:   res_ra = fix_pass ? {v, pv} : {pv, v};
      S_AWR: begin
        res_we = 1'b1;
        res_wa = fix_pass ? {v, pv} : {pv, v};
        res_wd = fix_pass ? res_q + neck : res_q - neck;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      node_count <= 5'd16;
      out_valid <= 1'b0;
      scan_vld <= 1'b0;
      visited <= '0;
      total <= '0;
    end else begin
      if (cfg_we) node_count <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == (AB+1)'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready && in_data.opcode == OP_SOLVE) begin
            n <= ncfg;
            src <= NB'(in_data.source_node);
            dst <= NB'(in_data.sink_node);
            total <= '0;
            if (in_data.source_node == in_data.sink_node
                || (NB+1)'(in_data.source_node) >= ncfg
                || (NB+1)'(in_data.sink_node) >= ncfg) begin
              err <= 1'b1;
              state <= S_DONE;
            end else begin
              err <= 1'b0;
              u <= '0;
              w <= '0;
              cnt <= '0;
              scan_vld <= 1'b0;
              state <= S_COPY;
            end
          end
        end
        S_COPY: begin
          // Read address cnt runs one step ahead of the write address {u, w}.
          if (scan_vld) begin
            if ((NB+1)'(w) == n - 1'b1) begin
              w <= '0;
              u <= u + 1'b1;
            end else w <= w + 1'b1;
          end
          scan_vld <= 1'b1;
          if (scan_vld && (NB+1)'(u) == n - 1'b1 && (NB+1)'(w) == n - 1'b1) begin
            scan_vld <= 1'b0;
            state <= S_BINIT;
          end else if ((NB+1)'(cnt[NB-1:0]) == n - 1'b1) begin
            cnt <= {cnt[AB:NB] + 1'b1, NB'(0)};
          end else cnt <= cnt + 1'b1;
        end
        S_BINIT: begin
          visited <= MAX_NODES'(1) << src;
          parent[src] <= src;
          queue[0] <= src;
          head <= '0;
          tail <= (NB+1)'(1);
          state <= S_BPOP;
        end
        S_BPOP: begin
          if (head < tail) begin
            u <= queue[head[NB-1:0]];
            head <= head + 1'b1;
            scan <= '0;
            scan_vld <= 1'b0;
            state <= S_BSCAN;
          end else if (visited[dst]) begin
            v <= dst;
            steps <= '0;
            neck <= '1;
            state <= S_NRD;
          end else state <= S_DONE;
        end
        S_BSCAN: begin
          // The entry read last cycle belongs to node w.
          if (scan_vld && !visited[w] && res_q != '0) begin
            visited[w] <= 1'b1;
            parent[w] <= u;
            if (tail < (NB+1)'(MAX_NODES)) begin
              queue[tail[NB-1:0]] <= w;
              tail <= tail + 1'b1;
            end
          end
          w <= scan[NB-1:0];
          scan_vld <= (scan < n);
          if (scan == n) state <= S_BPOP;
          else scan <= scan + 1'b1;
        end
        S_NRD: begin
          if (v == src || steps == n) begin
            v <= dst;
            steps <= '0;
            fix_pass <= 1'b0;
            state <= S_ARD;
          end else state <= S_NWT;
        end
        S_NWT: begin
          if (res_q < neck) neck <= res_q;
          v <= pv;
          steps <= steps + 1'b1;
          state <= S_NRD;
        end
        S_ARD: begin
          if (v == src || steps == n) begin
            if (21'(total) + 21'(neck) > 21'(FLOW_MAX)) total <= FLOW_MAX;
            else total <= 20'(21'(total) + 21'(neck));
            state <= S_BINIT;
          end else state <= S_AWR;
        end
        S_AWR: begin
          if (fix_pass) begin
            fix_pass <= 1'b0;
            v <= pv;
            steps <= steps + 1'b1;
          end else fix_pass <= 1'b1;
          state <= S_ARD;
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data.flow_value <= err ? '0 : total;
            out_data.error <= err;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error |-> out_data.flow_value == '0) else $error("error flow");
  a_src_visit: assert property (@(posedge clk) disable iff (rst)
    state == S_BSCAN |-> visited[src]) else $error("source unvisited");
  a_tail: assert property (@(posedge clk) disable iff (rst)
    state == S_BPOP |-> head <= tail) else $error("queue underflow");
`endif
endmodule
`default_nettype wire
